### sv/mrbg_pkg.sv
// ----------------------------------------------------------------------------
// mrbg_pkg
// Shared types, constants and helpers for the motor reversal brake gate.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbg_pkg;

    // field widths
    localparam int DRIVE_W     = 15;
    localparam int TICK_W      = 16;
    localparam int THRESH_W    = 14;
    localparam int DURATION_W  = 24;
    localparam int MAG_W       = DRIVE_W + 1;
    localparam int MOTOR_IDX_W = 1;
    localparam int MOTOR_COUNT = 2;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = DURATION_W;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION  = 1'd1;

    // saturation value of the brake timer
    localparam logic [DURATION_W-1:0] ELAPSED_MAX = {DURATION_W{1'b1}};

    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic [MOTOR_IDX_W-1:0]    motor_idx_t;

    // one input request
    typedef struct packed {
        drive_t                  drive_value;
        motor_idx_t              motor_index;
        logic [TICK_W-1:0]       tick_us;
    } item_t;

    // one result request
    typedef struct packed {
        drive_t drive_out;
        logic   braking;
    } result_t;

    // magnitude of a drive command, one bit wider so that the most negative fits
    function automatic logic [MAG_W-1:0] drive_mag(input drive_t v);
        logic signed [MAG_W-1:0] w;
        begin
            w = {v[DRIVE_W-1], v};
            drive_mag = v[DRIVE_W-1] ? MAG_W'(-w) : MAG_W'(w);
        end
    endfunction

endpackage

`default_nettype wire

### sv/motor_reversal_brake_gate_core.sv
// Path: an accepted request is captured in the input register, then its result
// in the result register; a full result register stalls the move between them.
// Throughput: one request per cycle; the input register and the result
// register each hold one request, so full rate needs m_ready high.
// Reset (aresetn low, synchronous) clears both registers' valid flags,
// every motor's last command, brake flag and brake timer, and both
// configuration registers.
// ----------------------------------------------------------------------------
// motor_reversal_brake_gate_core
// Forces a motor command to zero for a hold time after a small-magnitude
// direction reversal, with independent brake state per motor.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_reversal_brake_gate_core (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration writes
    input  wire logic                                    cfg_wr_en,
    input  wire logic [mrbg_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [mrbg_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // command requests
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [mrbg_pkg::DRIVE_W-1:0]     s_drive_value,
    input  wire logic [mrbg_pkg::MOTOR_IDX_W-1:0]        s_motor_index,
    input  wire logic [mrbg_pkg::TICK_W-1:0]             s_tick_us,
    // result requests
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [mrbg_pkg::DRIVE_W-1:0]          m_drive_out,
    output logic                                         m_braking
);
    import mrbg_pkg::*;

    logic [THRESH_W-1:0]   threshold_reg;
    logic [DURATION_W-1:0] duration_reg;

    item_t   item_in;
    item_t   item_q;
    logic    item_valid;
    result_t result_d;
    result_t result_q;
    logic    out_valid;
    logic    advance;
    logic    load_in;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            duration_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                REG_DURATION:  duration_reg  <= cfg_wdata[DURATION_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control between the two registers
    assign advance = item_valid && (!out_valid || m_ready);
    assign s_ready = !item_valid || advance;
    assign load_in = s_valid && s_ready;

    assign item_in.drive_value = s_drive_value;
    assign item_in.motor_index = s_motor_index;
    assign item_in.tick_us     = s_tick_us;

    mrbg_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load_in),
        .advance    (advance),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    mrbg_gate u_gate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item_q),
        .threshold (threshold_reg),
        .duration  (duration_reg),
        .result    (result_d)
    );

    mrbg_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance),
        .take         (m_ready),
        .result_in    (result_d),
        .result_valid (out_valid),
        .result_out   (result_q)
    );

    assign m_valid     = out_valid;
    assign m_drive_out = result_q.drive_out;
    assign m_braking   = result_q.braking;

`ifndef SYNTHESIS
    // a request leaving the input register always lands in the result register
    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced request did not reach the result register");

    // a braked result carries a zero command
    a_braked_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_braking) |-> (m_drive_out == '0))
        else $error("braked result with nonzero command");
`endif

endmodule

`default_nettype wire

### sv/mrbg_in_reg.sv
// ----------------------------------------------------------------------------
// mrbg_in_reg
// Input register: captures one request and holds it until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbg_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire logic           advance,
    input  mrbg_pkg::item_t     item_in,
    output logic                item_valid,
    output mrbg_pkg::item_t     item_out
);
    import mrbg_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

`default_nettype wire

### sv/mrbg_gate.sv
// ----------------------------------------------------------------------------
// mrbg_gate
// Per-motor brake state and the reversal / brake hold decision.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbg_gate (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   advance,
    input  mrbg_pkg::item_t                             item,
    input  wire logic [mrbg_pkg::THRESH_W-1:0]          threshold,
    input  wire logic [mrbg_pkg::DURATION_W-1:0]        duration,
    output mrbg_pkg::result_t                           result
);
    import mrbg_pkg::*;

    drive_t                prev_reg    [MOTOR_COUNT];
    logic                  active_reg  [MOTOR_COUNT];
    logic [DURATION_W-1:0] elapsed_reg [MOTOR_COUNT];

    drive_t                prev_cur;
    logic                  active_cur;
    logic [DURATION_W-1:0] elapsed_cur;
    logic                  idx_ok;
    logic                  now_pos;
    logic                  now_neg;
    logic                  prev_pos;
    logic                  prev_neg;
    logic [MAG_W-1:0]      thr_ext;
    logic                  reversal;
    logic [DURATION_W:0]   sum;
    logic [DURATION_W-1:0] elapsed_sat;
    logic                  start;
    logic                  hold;

    drive_t                prev_next;
    logic                  active_next;
    logic [DURATION_W-1:0] elapsed_next;

    // read the addressed motor
    assign idx_ok      = (32'(item.motor_index) < 32'(MOTOR_COUNT));
    assign prev_cur    = prev_reg[item.motor_index];
    assign active_cur  = active_reg[item.motor_index];
    assign elapsed_cur = elapsed_reg[item.motor_index];

    // strict sign reversal with both magnitudes under threshold
    assign now_neg  = item.drive_value[DRIVE_W-1];
    assign now_pos  = !now_neg && (item.drive_value != '0);
    assign prev_neg = prev_cur[DRIVE_W-1];
    assign prev_pos = !prev_neg && (prev_cur != '0);
    assign thr_ext  = MAG_W'(threshold);
    assign reversal = ((now_pos && prev_neg) || (now_neg && prev_pos))
                      && (drive_mag(item.drive_value) < thr_ext)
                      && (drive_mag(prev_cur) < thr_ext);

    // saturating brake timer
    assign sum         = {1'b0, elapsed_cur} + (DURATION_W+1)'(item.tick_us);
    assign elapsed_sat = sum[DURATION_W] ? ELAPSED_MAX : sum[DURATION_W-1:0];

    assign start = idx_ok && !active_cur && reversal;
    assign hold  = idx_ok && active_cur && (elapsed_sat < duration);

    // next state of the addressed motor
    always_comb begin
        prev_next    = prev_cur;
        active_next  = active_cur;
        elapsed_next = elapsed_cur;
        if (start) begin
            active_next  = 1'b1;
            elapsed_next = '0;
            prev_next    = item.drive_value;
        end else begin
            if (active_cur) begin
                elapsed_next = elapsed_sat;
                if (!hold) begin
                    active_next = 1'b0;
                end
            end
            if (!hold) begin
                prev_next = item.drive_value;
            end
        end
    end

    // result
    always_comb begin
        result.braking   = start || hold;
        result.drive_out = (start || hold) ? drive_t'('0) : item.drive_value;
    end

    // per-motor state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                prev_reg[i]    <= '0;
                active_reg[i]  <= 1'b0;
                elapsed_reg[i] <= '0;
            end
        end else if (advance && idx_ok) begin
            prev_reg[item.motor_index]    <= prev_next;
            active_reg[item.motor_index]  <= active_next;
            elapsed_reg[item.motor_index] <= elapsed_next;
        end
    end

`ifndef SYNTHESIS
    // a started brake leaves that motor braking with a cleared timer
    a_start_sets_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && start) |=> (active_reg[$past(item.motor_index)]
                                && elapsed_reg[$past(item.motor_index)] == '0))
        else $error("brake start did not arm motor state");

    // with zero duration no request after the first is held
    a_zero_duration: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && duration == '0) |-> !hold)
        else $error("brake held with zero duration");
`endif

endmodule

`default_nettype wire

### sv/mrbg_out_reg.sv
// ----------------------------------------------------------------------------
// mrbg_out_reg
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbg_out_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire logic           take,
    input  mrbg_pkg::result_t   result_in,
    output logic                result_valid,
    output mrbg_pkg::result_t   result_out
);
    import mrbg_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

endmodule

`default_nettype wire
